@@ hdl/iefa_pkg.sv @@
// Shared types, codes and helpers for the input event filter with autorepeat.
// Used by every module of the block; no dependencies.
`default_nettype none

package iefa_pkg;

  // default sizes
  localparam int NUM_KEYS_DEF = 512;
  localparam int NUM_ABS_DEF  = 64;
  localparam int TPS_DEF      = 100;

  // fixed code ranges of the small stores
  localparam int NUM_REL = 16;
  localparam int NUM_LED = 16;
  localparam int NUM_SND = 8;
  localparam int NUM_REP = 2;

  // key state and capability rows
  localparam int ROW_BITS = 64;
  localparam int ROW_SH   = 6;

  // config port
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  localparam logic [2:0] REG_TYPE_EN = 3'd0;
  localparam logic [2:0] REG_ABS_EN  = 3'd1;
  localparam logic [2:0] REG_REL_EN  = 3'd2;
  localparam logic [2:0] REG_LED_EN  = 3'd3;
  localparam logic [2:0] REG_SND_EN  = 3'd4;

  localparam logic [1:0] REQ_EVENT = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;

  localparam logic [4:0] T_KEY = 5'd1;
  localparam logic [4:0] T_REL = 5'd2;
  localparam logic [4:0] T_ABS = 5'd3;
  localparam logic [4:0] T_LED = 5'd17;
  localparam logic [4:0] T_SND = 5'd18;
  localparam logic [4:0] T_REP = 5'd20;

  localparam logic [31:0] KEY_REPEAT = 32'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [4:0]         event_type;
    logic [8:0]         event_code;
    logic signed [31:0] event_value;
    logic [2:0]         cap_index;
    logic [63:0]        cap_word;
  } in_word_t;

  typedef struct packed {
    logic [4:0]         out_type;
    logic [8:0]         out_code;
    logic signed [31:0] out_value;
    logic               to_device;
  } out_word_t;

  typedef struct packed {
    logic [31:0] type_enable;
    logic [63:0] abs_enable;
    logic [15:0] rel_enable;
    logic [15:0] led_enable;
    logic [7:0]  snd_enable;
  } cfg_t;

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // non-positive delays fire on the next tick
  function automatic logic [31:0] ticks_of(input logic [31:0] v);
    return ((v == 32'd0) || v[31]) ? 32'd1 : v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/iefa_regs.sv @@
// APB-style configuration registers of the event filter.
// Depends on iefa_pkg for cfg_t and register indexes.
`default_nettype none

module iefa_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [iefa_pkg::CFG_AW-1:0] paddr,
  input  wire logic [iefa_pkg::CFG_DW-1:0] pwdata,
  output logic      [iefa_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output iefa_pkg::cfg_t                   cfg
);
  import iefa_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[CFG_AW-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_TYPE_EN: cfg_nxt.type_enable = pwdata[31:0];
        REG_ABS_EN:  cfg_nxt.abs_enable  = pwdata;
        REG_REL_EN:  cfg_nxt.rel_enable  = pwdata[15:0];
        REG_LED_EN:  cfg_nxt.led_enable  = pwdata[15:0];
        REG_SND_EN:  cfg_nxt.snd_enable  = pwdata[7:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TYPE_EN: prdata = {32'd0, cfg_r.type_enable};
      REG_ABS_EN:  prdata = cfg_r.abs_enable;
      REG_REL_EN:  prdata = {48'd0, cfg_r.rel_enable};
      REG_LED_EN:  prdata = {48'd0, cfg_r.led_enable};
      REG_SND_EN:  prdata = {56'd0, cfg_r.snd_enable};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/iefa_store.sv @@
// State memory with a valid bit per entry; unwritten entries read as zero.
// Registered read with write-to-read forwarding. Depends on iefa_pkg.
`default_nettype none

module iefa_store #(
  parameter  int DEPTH = 64,
  parameter  int WIDTH = 32,
  localparam int AW    = iefa_pkg::addr_bits(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);
  import iefa_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else if (!vld_r[rd_addr]) begin
        rd_data_r <= '0;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/iefa_filter.sv @@
// Event filter and autorepeat timer: decides drop or pass for one word and
// updates the small state registers and the store write ports. Uses iefa_pkg.
`default_nettype none

module iefa_filter #(
  parameter  int NUM_KEYS         = iefa_pkg::NUM_KEYS_DEF,
  parameter  int NUM_ABS          = iefa_pkg::NUM_ABS_DEF,
  parameter  int TICKS_PER_SECOND = iefa_pkg::TPS_DEF,
  localparam int KEY_ROWS         = (NUM_KEYS + iefa_pkg::ROW_BITS - 1) / iefa_pkg::ROW_BITS,
  localparam int KRW              = iefa_pkg::addr_bits(KEY_ROWS),
  localparam int AAW              = iefa_pkg::addr_bits(NUM_ABS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire iefa_pkg::in_word_t word,
  input  wire iefa_pkg::cfg_t     cfg,
  input  wire logic [63:0]        key_rd,
  input  wire logic [31:0]        abs_rd,
  output iefa_pkg::out_word_t     res,
  output logic                    res_vld,
  output logic                    key_we,
  output logic      [KRW-1:0]     key_waddr,
  output logic      [63:0]        key_wdata,
  output logic                    abs_we,
  output logic      [AAW-1:0]     abs_waddr,
  output logic      [31:0]        abs_wdata
);
  import iefa_pkg::*;

  logic [63:0] cap_r   [KEY_ROWS];
  logic [63:0] cap_nxt [KEY_ROWS];
  logic [31:0] rep_set_r   [NUM_REP];
  logic [31:0] rep_set_nxt [NUM_REP];
  logic [15:0] led_r, led_nxt;
  logic [7:0]  snd_r, snd_nxt;
  logic [8:0]  rcode_r, rcode_nxt;
  logic        armed_r, armed_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  logic        is_evt, is_tick, is_load, fire, active;
  logic [4:0]  f_t;
  logic [8:0]  f_c;
  logic [31:0] f_v;
  logic        kd, key_cap, pass, dev, kwe, awe;

  assign is_evt  = (word.req_type == REQ_EVENT);
  assign is_tick = (word.req_type == REQ_TICK);
  assign is_load = (word.req_type == REQ_LOAD);
  // countdown reaching one on a tick generates the repeat
  assign fire    = is_tick && armed_r && !(cnt_r > 32'd1);
  assign active  = is_evt || fire;

  assign f_t = fire ? T_KEY : word.event_type;
  assign f_c = fire ? rcode_r : word.event_code;
  assign f_v = fire ? KEY_REPEAT : word.event_value;

  // key_rd belongs to the event's own code; a generated repeat never uses kd
  assign kd      = key_rd[f_c[ROW_SH-1:0]];
  assign key_cap = (int'(f_c) < NUM_KEYS) ? cap_r[KRW'(f_c >> ROW_SH)][f_c[ROW_SH-1:0]] : 1'b0;

  always_comb begin
    pass        = 1'b0;
    dev         = 1'b0;
    kwe         = 1'b0;
    awe         = 1'b0;
    cap_nxt     = cap_r;
    rep_set_nxt = rep_set_r;
    led_nxt     = led_r;
    snd_nxt     = snd_r;
    rcode_nxt   = rcode_r;
    armed_nxt   = armed_r;
    cnt_nxt     = cnt_r;

    if (is_load && (int'(word.cap_index) < KEY_ROWS)) begin
      cap_nxt[KRW'(word.cap_index)] = word.cap_word;
    end

    if (active && cfg.type_enable[f_t]) begin
      case (f_t)
        T_KEY: begin
          if (key_cap && ({31'd0, kd} != f_v)) begin
            pass = 1'b1;
            if (f_v != KEY_REPEAT) begin
              kwe = 1'b1;
              if (cfg.type_enable[T_REP]) begin
                if (f_v != 32'd0) begin
                  armed_nxt = 1'b1;
                  cnt_nxt   = ticks_of(rep_set_r[0]);
                  rcode_nxt = f_c;
                end else if (rcode_r == f_c) begin
                  armed_nxt = 1'b0;
                end
              end
            end
          end
        end
        T_ABS: begin
          if ((int'(f_c) < NUM_ABS) && cfg.abs_enable[f_c[5:0]] && (abs_rd != f_v)) begin
            pass = 1'b1;
            awe  = 1'b1;
          end
        end
        T_REL: begin
          pass = (int'(f_c) < NUM_REL) && cfg.rel_enable[f_c[3:0]] && (f_v != 32'd0);
        end
        T_LED: begin
          if ((int'(f_c) < NUM_LED) && cfg.led_enable[f_c[3:0]]
              && ({31'd0, led_r[f_c[3:0]]} != f_v)) begin
            pass                = 1'b1;
            dev                 = 1'b1;
            led_nxt[f_c[3:0]]   = ~led_r[f_c[3:0]];
          end
        end
        T_SND: begin
          if ((int'(f_c) < NUM_SND) && cfg.snd_enable[f_c[2:0]]
              && ({31'd0, snd_r[f_c[2:0]]} != f_v)) begin
            pass                = 1'b1;
            dev                 = 1'b1;
            snd_nxt[f_c[2:0]]   = ~snd_r[f_c[2:0]];
          end
        end
        T_REP: begin
          if ((int'(f_c) < NUM_REP) && (rep_set_r[f_c[0]] != f_v)) begin
            pass                = 1'b1;
            dev                 = 1'b1;
            rep_set_nxt[f_c[0]] = f_v;
          end
        end
        default: pass = 1'b1;
      endcase
    end

    // re-arm with the period even when the generated repeat is dropped
    if (is_tick && armed_r) begin
      if (cnt_r > 32'd1) begin
        cnt_nxt = cnt_r - 32'd1;
      end else begin
        armed_nxt = 1'b1;
        cnt_nxt   = ticks_of(rep_set_r[1]);
      end
    end
  end

  assign res_vld       = pass;
  assign res.out_type  = f_t;
  assign res.out_code  = f_c;
  assign res.out_value = f_v;
  assign res.to_device = dev;

  assign key_we    = adv && kwe;
  assign key_waddr = KRW'(f_c >> ROW_SH);
  assign key_wdata = key_rd ^ (64'd1 << f_c[ROW_SH-1:0]);
  assign abs_we    = adv && awe;
  assign abs_waddr = AAW'(f_c);
  assign abs_wdata = f_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_ROWS; i++) begin
        cap_r[i] <= '0;
      end
      rep_set_r[0] <= 32'(TICKS_PER_SECOND / 4);
      rep_set_r[1] <= 32'(TICKS_PER_SECOND / 33);
      led_r        <= '0;
      snd_r        <= '0;
      rcode_r      <= '0;
      armed_r      <= 1'b0;
      cnt_r        <= '0;
    end else if (adv) begin
      cap_r     <= cap_nxt;
      rep_set_r <= rep_set_nxt;
      led_r     <= led_nxt;
      snd_r     <= snd_nxt;
      rcode_r   <= rcode_nxt;
      armed_r   <= armed_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/input_event_filter_autorepeat.sv @@
// Input event filter with key autorepeat, top level.
// Path: an accepted input word passes the input stage (with store read), then
// the result register, from which its result word leaves.
// Throughput: one word per cycle; stall on the output holds the input stage.
// Reset (synchronous, rst_n low) clears config, state registers and the store
// valid bits at once; no clearing pass is needed.
`default_nettype none

module input_event_filter_autorepeat #(
  parameter int NUM_KEYS         = iefa_pkg::NUM_KEYS_DEF,
  parameter int NUM_ABS          = iefa_pkg::NUM_ABS_DEF,
  parameter int TICKS_PER_SECOND = iefa_pkg::TPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire iefa_pkg::in_word_t          in_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output iefa_pkg::out_word_t              out_word,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [iefa_pkg::CFG_AW-1:0] paddr,
  input  wire logic [iefa_pkg::CFG_DW-1:0] pwdata,
  output logic      [iefa_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);
  import iefa_pkg::*;

  localparam int KEY_ROWS = (NUM_KEYS + ROW_BITS - 1) / ROW_BITS;
  localparam int KRW      = addr_bits(KEY_ROWS);
  localparam int AAW      = addr_bits(NUM_ABS);

  cfg_t      cfg;
  in_word_t  s1_word_r;
  logic      s1_vld_r, s1_vld_nxt;
  out_word_t out_word_r, res;
  logic      out_vld_r, out_vld_nxt;
  logic      res_vld, adv, accept;

  logic [63:0]    key_rd, key_wdata;
  logic [31:0]    abs_rd, abs_wdata;
  logic           key_we, abs_we;
  logic [KRW-1:0] key_waddr;
  logic [AAW-1:0] abs_waddr;

  assign adv       = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = s1_vld_r && !adv;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = res_vld;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
    end
    if (adv) begin
      out_word_r <= res;
    end
  end

  iefa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // key state rows, read alongside the input stage
  iefa_store #(
    .DEPTH (KEY_ROWS),
    .WIDTH (ROW_BITS)
  ) u_key_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (KRW'(in_word.event_code >> ROW_SH)),
    .rd_data (key_rd),
    .wr_en   (key_we),
    .wr_addr (key_waddr),
    .wr_data (key_wdata)
  );

  iefa_store #(
    .DEPTH (NUM_ABS),
    .WIDTH (32)
  ) u_abs_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (AAW'(in_word.event_code)),
    .rd_data (abs_rd),
    .wr_en   (abs_we),
    .wr_addr (abs_waddr),
    .wr_data (abs_wdata)
  );

  iefa_filter #(
    .NUM_KEYS         (NUM_KEYS),
    .NUM_ABS          (NUM_ABS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .word      (s1_word_r),
    .cfg       (cfg),
    .key_rd    (key_rd),
    .abs_rd    (abs_rd),
    .res       (res),
    .res_vld   (res_vld),
    .key_we    (key_we),
    .key_waddr (key_waddr),
    .key_wdata (key_wdata),
    .abs_we    (abs_we),
    .abs_waddr (abs_waddr),
    .abs_wdata (abs_wdata)
  );

endmodule

`default_nettype wire

@@ bench/event_filter_checker.sv @@
`timescale 1ns / 1ps
// Checker for input_event_filter_autorepeat: follows the filter, the stores and the
// autorepeat timer from every accepted word and compares result words in order.
// Depends on iefa_pkg.
module event_filter_checker
  import iefa_pkg::*;
#(
  parameter int NUM_KEYS         = NUM_KEYS_DEF,
  parameter int NUM_ABS          = NUM_ABS_DEF,
  parameter int TICKS_PER_SECOND = TPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_word_t          in_word,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                pending,
  output int                n_errors
);

  // configuration copy
  logic [31:0] type_en;
  logic [63:0] abs_en;
  logic [15:0] rel_en;
  logic [15:0] led_en;
  logic [7:0]  snd_en;

  // device state copy
  logic        key_down [NUM_KEYS];
  logic [63:0] key_cap  [(NUM_KEYS + 63) / 64];
  logic [31:0] abs_val  [NUM_ABS];
  logic [15:0] led_on;
  logic [7:0]  snd_on;
  logic [31:0] rep_set  [NUM_REP];  // 0 delay, 1 period
  logic [8:0]  rep_code;
  logic        rep_armed;
  logic [31:0] rep_count;

  out_word_t event_queue [$];

  initial n_errors = 0;
  initial pending = 0;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("[%0t] checker: %s: expected %h, got %h", $time, what, want, got);
    n_errors++;
  endtask

  // zero or negative counts run out on the next tick
  function automatic logic [31:0] repeat_ticks(input logic [31:0] v);
    if (v == 32'd0 || v[31]) return 32'd1;
    return v;
  endfunction

  // Applies one event to the state; returns 1 when it passes the filter.
  function automatic bit filter_event(input logic [4:0] t, input logic [8:0] c,
                                      input logic [31:0] v, output out_word_t r);
    logic dev;
    dev = 1'b0;
    r = '0;
    if (!type_en[t]) return 1'b0;
    case (t)
      T_KEY: begin
        if (c >= NUM_KEYS || !key_cap[c[8:6]][c[5:0]]) return 1'b0;
        if ({31'd0, key_down[c]} == v) return 1'b0;
        if (v != KEY_REPEAT) begin
          key_down[c] = ~key_down[c];
          if (type_en[T_REP]) begin
            if (v != 32'd0) begin
              rep_armed = 1'b1;
              rep_count = repeat_ticks(rep_set[0]);
              rep_code  = c;
            end else if (rep_code == c) begin
              rep_armed = 1'b0;
            end
          end
        end
      end
      T_ABS: begin
        if (c >= NUM_ABS || !abs_en[c[5:0]] || abs_val[c[5:0]] == v) return 1'b0;
        abs_val[c[5:0]] = v;
      end
      T_REL: begin
        if (c >= NUM_REL || !rel_en[c[3:0]] || v == 32'd0) return 1'b0;
      end
      T_LED: begin
        if (c >= NUM_LED || !led_en[c[3:0]] || {31'd0, led_on[c[3:0]]} == v) return 1'b0;
        led_on[c[3:0]] = ~led_on[c[3:0]];
        dev = 1'b1;
      end
      T_SND: begin
        if (c >= NUM_SND || !snd_en[c[2:0]] || {31'd0, snd_on[c[2:0]]} == v) return 1'b0;
        snd_on[c[2:0]] = ~snd_on[c[2:0]];
        dev = 1'b1;
      end
      T_REP: begin
        if (c >= NUM_REP || rep_set[c[0]] == v) return 1'b0;
        rep_set[c[0]] = v;
        dev = 1'b1;
      end
      default: ;
    endcase
    r.out_type  = t;
    r.out_code  = c;
    r.out_value = v;
    r.to_device = dev;
    return 1'b1;
  endfunction

  function automatic bit step_word(input in_word_t w, output out_word_t r);
    bit hit;
    r = '0;
    case (w.req_type)
      REQ_EVENT: return filter_event(w.event_type, w.event_code, w.event_value, r);
      REQ_LOAD: begin
        if (w.cap_index < (NUM_KEYS + 63) / 64) key_cap[w.cap_index] = w.cap_word;
        return 1'b0;
      end
      REQ_TICK: begin
        if (!rep_armed) return 1'b0;
        if (rep_count > 32'd1) begin
          rep_count--;
          return 1'b0;
        end
        // a filtered-out repeat still reloads the timer
        hit = filter_event(T_KEY, rep_code, KEY_REPEAT, r);
        rep_armed = 1'b1;
        rep_count = repeat_ticks(rep_set[1]);
        return hit;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    out_word_t want, got;
    if (!rst_n) begin
      type_en = '0;
      abs_en  = '0;
      rel_en  = '0;
      led_en  = '0;
      snd_en  = '0;
      for (int i = 0; i < NUM_KEYS; i++) key_down[i] = 1'b0;
      for (int i = 0; i < (NUM_KEYS + 63) / 64; i++) key_cap[i] = '0;
      for (int i = 0; i < NUM_ABS; i++) abs_val[i] = '0;
      led_on    = '0;
      snd_on    = '0;
      rep_set[0] = TICKS_PER_SECOND / 4;
      rep_set[1] = TICKS_PER_SECOND / 33;
      rep_code  = '0;
      rep_armed = 1'b0;
      rep_count = '0;
      event_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_AW-1:3])
          REG_TYPE_EN: type_en = pwdata[31:0];
          REG_ABS_EN:  abs_en  = pwdata[63:0];
          REG_REL_EN:  rel_en  = pwdata[15:0];
          REG_LED_EN:  led_en  = pwdata[15:0];
          REG_SND_EN:  snd_en  = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_word;
        if (event_queue.size() == 0) begin
          report_mismatch("result word with nothing expected", '0, 64'(got));
        end else begin
          want = event_queue.pop_front();
          if (got.out_type !== want.out_type)
            report_mismatch("out_type", 64'(want.out_type), 64'(got.out_type));
          if (got.out_code !== want.out_code)
            report_mismatch("out_code", 64'(want.out_code), 64'(got.out_code));
          if (got.out_value !== want.out_value)
            report_mismatch("out_value", 64'(unsigned'(want.out_value)),
                            64'(unsigned'(got.out_value)));
          if (got.to_device !== want.to_device)
            report_mismatch("to_device", 64'(want.to_device), 64'(got.to_device));
        end
      end
      if (in_valid && !in_stall) begin
        if (step_word(in_word, want)) event_queue.push_back(want);
      end
    end
    pending <= event_queue.size();
  end

endmodule

@@ bench/tb_input_event_filter_autorepeat.sv @@
`timescale 1ns / 1ps
// Top of the bench for input_event_filter_autorepeat: clock, reset, APB setup,
// directed and random words, receiver stalls and the verdict.
// Depends on iefa_pkg, the block and event_filter_checker.
module tb_input_event_filter_autorepeat;
  import iefa_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 340;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic        pready;

  int pending;
  int n_errors;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  input_event_filter_autorepeat dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  event_filter_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .pending(pending), .n_errors(n_errors)
  );

  // stall watchdog: any accepted or delivered word or register access counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[input_event_filter_autorepeat] ERROR");
      $finish;
    end
  end

  // receiver: segments of random stall patterns, plus one long hold-off on request
  initial begin : receiver
    int seg_left;
    int mode;
    seg_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        mode = $urandom_range(0, 3);
      end
      seg_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= seg_left[2];
      endcase
    end
  end

  // every word starts from random bits so unused fields toggle too
  function automatic in_word_t noise_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t event_word(input logic [4:0] t, input logic [8:0] c,
                                          input logic [31:0] v);
    in_word_t w;
    w = noise_word();
    w.req_type    = REQ_EVENT;
    w.event_type  = t;
    w.event_code  = c;
    w.event_value = v;
    return w;
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w = noise_word();
    w.req_type = REQ_TICK;
    return w;
  endfunction

  function automatic in_word_t load_word(input logic [2:0] idx, input logic [63:0] bits);
    in_word_t w;
    w = noise_word();
    w.req_type  = REQ_LOAD;
    w.cap_index = idx;
    w.cap_word  = bits;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    int sub;
    w = noise_word();
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 19);
    if (pick < 20) begin
      w.req_type = REQ_TICK;
    end else if (pick < 27) begin
      w.req_type = REQ_LOAD;
      if (sub < 12) w.cap_word = '1;
    end else if (pick < 30) begin
      w.req_type = REQ_UNKNOWN;
    end else begin
      w.req_type = REQ_EVENT;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        w.event_type = T_KEY;
        if ($urandom_range(0, 9) < 7) w.event_code = 9'($urandom_range(0, 7));
        if (sub < 8) w.event_value = 32'd1;
        else if (sub < 15) w.event_value = 32'd0;
        else if (sub < 17) w.event_value = KEY_REPEAT;
      end else if (pick < 50) begin
        w.event_type = T_REL;
        if (sub < 18) w.event_code = 9'($urandom_range(0, 17));
        if (sub < 6) w.event_value = 32'd0;
      end else if (pick < 62) begin
        w.event_type = T_ABS;
        if ($urandom_range(0, 9) < 7) w.event_code = 9'($urandom_range(0, 7));
        if (sub < 10) w.event_value = 32'($urandom_range(0, 3));
      end else if (pick < 74) begin
        w.event_type = T_LED;
        if (sub < 18) w.event_code = 9'($urandom_range(0, 17));
        if (sub < 18) w.event_value = 32'($urandom_range(0, 1));
      end else if (pick < 84) begin
        w.event_type = T_SND;
        if (sub < 18) w.event_code = 9'($urandom_range(0, 9));
        if (sub < 18) w.event_value = 32'($urandom_range(0, 1));
      end else if (pick < 90) begin
        // keep delays short so the timer fires often
        w.event_type = T_REP;
        if (sub < 18) w.event_code = 9'($urandom_range(0, 2));
        if (sub < 16) w.event_value = 32'($urandom_range(0, 4));
        else if (sub < 18) w.event_value = -32'($urandom_range(1, 3));
      end
    end
    return w;
  endfunction

  task automatic offer(input in_word_t w);
    int gap;
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gaps_on && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending until every expected word is back, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_filter(input logic [63:0] types, input logic [63:0] absm,
                                input logic [63:0] relm, input logic [63:0] ledm,
                                input logic [63:0] sndm);
    cfg_write(REG_TYPE_EN, types);
    cfg_write(REG_ABS_EN, absm);
    cfg_write(REG_REL_EN, relm);
    cfg_write(REG_LED_EN, ledm);
    cfg_write(REG_SND_EN, sndm);
  endtask

  initial begin : stimulus
    logic [63:0] core_types;
    core_types = (64'd1 << T_KEY) | (64'd1 << T_REL) | (64'd1 << T_ABS) |
                 (64'd1 << T_LED) | (64'd1 << T_SND) | (64'd1 << T_REP);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all types disabled after reset: nothing comes out
    offer(noise_word() | in_word_t'({REQ_UNKNOWN, 113'd0}));
    offer(event_word(T_KEY, 9'd5, 32'd1));
    drain();
    program_filter('1, '1, '1, '1, '1);

    offer(load_word(3'd0, '1));
    offer(load_word(3'd7, 64'h8000_0000_0000_0001));
    offer(event_word(T_KEY, 9'd5, 32'd1));
    offer(event_word(T_KEY, 9'd5, 32'd1));           // same state, dropped
    offer(event_word(T_KEY, 9'd5, KEY_REPEAT));      // outside repeat passes
    offer(event_word(T_KEY, 9'd5, 32'd7));           // odd value toggles
    offer(event_word(T_KEY, 9'd511, 32'd1));
    offer(event_word(T_KEY, 9'd100, 32'd1));         // no capability
    offer(event_word(T_KEY, 9'd511, 32'd0));
    offer(event_word(T_REL, 9'd0, 32'd0));           // zero move
    offer(event_word(T_REL, 9'd15, 32'h8000_0000));
    offer(event_word(T_REL, 9'd16, 32'd1));
    offer(event_word(T_ABS, 9'd63, 32'h7fff_ffff));
    offer(event_word(T_ABS, 9'd63, 32'h7fff_ffff));
    offer(event_word(T_ABS, 9'd0, 32'h8000_0000));
    offer(event_word(T_LED, 9'd15, 32'd1));
    offer(event_word(T_LED, 9'd15, 32'd1));
    offer(event_word(T_LED, 9'd16, 32'd1));
    offer(event_word(T_SND, 9'd7, 32'd1));
    offer(event_word(T_SND, 9'd8, 32'd1));
    offer(event_word(T_REP, 9'd0, 32'd0));           // zero delay
    offer(event_word(T_REP, 9'd1, 32'hffff_ffff));   // negative period
    offer(event_word(T_REP, 9'd2, 32'd5));
    offer(event_word(5'd31, 9'd511, $urandom));
    offer(event_word(5'd0, 9'd0, 32'd0));
    offer(event_word(T_KEY, 9'd0, 32'd1));
    offer(tick_word());
    offer(tick_word());
    offer(event_word(T_KEY, 9'd0, 32'd0));
    offer(tick_word());
    // repeat of a key that lost capability is dropped but reloads the timer
    offer(event_word(T_KEY, 9'd1, 32'd1));
    offer(load_word(3'd0, '0));
    offer(tick_word());
    offer(load_word(3'd0, '1));
    offer(tick_word());

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: program_filter('1, '1, '1, '1, '1);
        1: program_filter({$urandom, $urandom} | core_types, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        2: program_filter(({$urandom, $urandom} | core_types) & ~(64'd1 << T_REP),
                          {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
        3: program_filter({$urandom, $urandom}, '0, '0, '0, '0);
        default: program_filter('1, '1, '1, '1, '1);
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 1 && n == 100) begin
          gaps_on = 1'b0;
          hold_request = 1'b1;
        end
        if (phase == 1 && n == 250) gaps_on = 1'b1;
        if ($urandom_range(0, 149) == 0) drain();
        offer(random_word());
      end
    end
    drain();

    if (n_errors == 0) begin
      $display("[input_event_filter_autorepeat] OK");
    end else begin
      $display("[input_event_filter_autorepeat] ERROR");
    end
    $finish;
  end

endmodule

@@ input_event_filter_autorepeat.f @@
hdl/iefa_pkg.sv
hdl/iefa_regs.sv
hdl/iefa_store.sv
hdl/iefa_filter.sv
hdl/input_event_filter_autorepeat.sv
bench/event_filter_checker.sv
bench/tb_input_event_filter_autorepeat.sv
